[rtl/assert_macros.svh]
// assertion macros used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, quiet while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// implication form of the same check
`define ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

`endif

[rtl/mst_pkg.sv]
// types and constants of the memory self-test sequencer
package mst_pkg;

    // default geometry of the memory under test
    localparam int ADDR_BITS_DEF   = 24;
    localparam int ERASE_BYTES_DEF = 4096;

    // fixed field widths
    localparam int MEM_SIZE_W = 25;
    localparam int ADDR_OUT_W = 24;
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 3;

    // configuration register indexes
    localparam logic CFG_NEEDS_ERASE = 1'b0;
    localparam logic CFG_MEM_SIZE    = 1'b1;

    // input command codes
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    // test patterns
    localparam logic [BYTE_W-1:0] BYTE_ONES    = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZEROS   = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_PATTERN = 8'h55;

    // memory operation issued with each result
    typedef enum logic [1:0] {
        OP_ERASE = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_DONE  = 2'd3
    } op_t;

    // outstanding step in flash mode
    localparam logic [PHASE_W-1:0] F_ERASE    = 3'd0;
    localparam logic [PHASE_W-1:0] F_CHK_BASE = 3'd1;
    localparam logic [PHASE_W-1:0] F_CHK_LAST = 3'd2;
    localparam logic [PHASE_W-1:0] F_WR_BASE  = 3'd3;
    localparam logic [PHASE_W-1:0] F_RD_BASE  = 3'd4;
    localparam logic [PHASE_W-1:0] F_WR_LAST  = 3'd5;
    localparam logic [PHASE_W-1:0] F_RD_LAST  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_INVALID = 3'd7;

    // outstanding step in byte mode
    localparam logic [PHASE_W-1:0] B_WR_ONES  = 3'd0;
    localparam logic [PHASE_W-1:0] B_RD_ONES  = 3'd1;
    localparam logic [PHASE_W-1:0] B_WR_ZEROS = 3'd2;
    localparam logic [PHASE_W-1:0] B_RD_ZEROS = 3'd3;

endpackage

[rtl/memory_self_test_sequencer.sv]
// memory self-test sequencer: one memory operation per response transaction
//
// A start transaction (tuser = 0) begins a test of the memory under test; each
// following response transaction (tuser = 1) reports the outcome of the last
// issued operation and yields the next operation, or a finished result with a
// pass/fail flag. In flash mode every whole sector is erased, checked for 0xFF
// at its first and last byte, then written and read back with 0x00 at the
// first and 0x55 at the last byte; in byte mode every address gets write 0xFF,
// read, write 0x00, read. A response while no test runs gives no result. The
// block takes one transaction per cycle unless the result register stalls:
// an input register and a result register hold the only state on the path,
// and the next operation and the test state are computed combinationally
// between them, so each result is offered from the result register. s_tready stays
// high unless the input register is full and the result register is stalled.
// Configuration is read live and should be written between tests.
`include "assert_macros.svh"

module memory_self_test_sequencer
    import mst_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int ERASE_BYTES = ERASE_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [MEM_SIZE_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // access_ok, read_data, zero pad
    input  logic [0:0]            s_tuser,  // command
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,  // target_address, write_value,
                                            // test_passed, zero pad
    output logic [1:0]            m_tuser   // operation
);

    localparam int SB    = $clog2(ERASE_BYTES);
    localparam int CMP_W = ((ADDR_BITS > MEM_SIZE_W) ? ADDR_BITS : MEM_SIZE_W) + 1;

    // byte address of a sector base, wrapped to the address space
    function automatic logic [ADDR_BITS-1:0] sector_base(input logic [ADDR_BITS-1:0] p);
        logic [ADDR_BITS+SB-1:0] w;
        w = {p, {SB{1'b0}}};
        return w[ADDR_BITS-1:0];
    endfunction

    // address space to result field width
    function automatic logic [ADDR_OUT_W-1:0] to_out(input logic [ADDR_BITS-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[ADDR_OUT_W-1:0];
    endfunction

    // configuration registers
    logic                  needs_erase_reg;
    logic [MEM_SIZE_W-1:0] mem_size_reg;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              cmd_reg;
    logic              ok_reg;
    logic [BYTE_W-1:0] data_reg;

    // test state
    logic                 running_reg, running_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [ADDR_BITS-1:0] position_reg, position_next;
    logic [BYTE_W-1:0]    expected_reg, expected_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    op_t                   op_reg, op_next;
    logic [ADDR_OUT_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0]     wval_reg, wval_next;
    logic                  pass_reg, pass_next;

    logic s_accept;
    logic proceed;
    logic emit;

    // handshake
    assign proceed  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proceed;
    assign s_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needs_erase_reg <= 1'b0;
            mem_size_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NEEDS_ERASE: needs_erase_reg <= cfg_wdata[0];
                CFG_MEM_SIZE:    mem_size_reg    <= cfg_wdata;
            endcase
        end
    end

    // input register
    assign in_valid_next = s_accept ? 1'b1 : (proceed ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tuser[0];
            ok_reg   <= s_tdata[0];
            data_reg <= s_tdata[8:1];
        end
    end

    // number of units to test
    logic [CMP_W-1:0] size_ext, limit, eff_size, unit_count, nxt_pos;
    logic             unit_done;
    logic [ADDR_BITS-1:0] new_pos, new_base, base_a, last_a;

    always_comb begin
        size_ext   = CMP_W'(mem_size_reg);
        limit      = CMP_W'(1) << ADDR_BITS;
        eff_size   = (size_ext > limit) ? limit : size_ext;
        unit_count = needs_erase_reg ? (eff_size >> SB) : eff_size;
        nxt_pos    = (cmd_reg == CMD_START) ? '0 : CMP_W'(position_reg) + CMP_W'(1);
        unit_done  = nxt_pos >= unit_count;
        new_pos    = nxt_pos[ADDR_BITS-1:0];
        new_base   = sector_base(new_pos);
        base_a     = sector_base(position_reg);
        last_a     = base_a | ADDR_BITS'(ERASE_BYTES - 1);
    end

    // next operation and test state
    logic                 fin, fin_pass, beg, iss;
    logic [PHASE_W-1:0]   iss_ph;
    op_t                  iss_op;
    logic [ADDR_BITS-1:0] iss_addr;
    logic [BYTE_W-1:0]    iss_val;
    logic                 flash_read, byte_read, mismatch;

    always_comb begin
        fin      = 1'b0;
        fin_pass = 1'b0;
        beg      = 1'b0;
        iss      = 1'b0;
        iss_ph   = phase_reg;
        iss_op   = OP_DONE;
        iss_addr = '0;
        iss_val  = '0;
        flash_read = (phase_reg == F_CHK_BASE) || (phase_reg == F_CHK_LAST) ||
                     (phase_reg == F_RD_BASE) || (phase_reg == F_RD_LAST);
        byte_read  = (phase_reg == B_RD_ONES) || (phase_reg == B_RD_ZEROS);
        mismatch   = data_reg != expected_reg;

        if (cmd_reg == CMD_START) begin
            beg = 1'b1;
        end else if (!running_reg) begin
            fin = 1'b0;
        end else if (!ok_reg) begin
            fin = 1'b1;
        end else if (needs_erase_reg) begin
            if (flash_read && mismatch) begin
                fin = 1'b1;
            end else begin
                iss = 1'b1;
                case (phase_reg)
                    F_ERASE: begin
                        iss_ph = F_CHK_BASE; iss_op = OP_READ;
                        iss_addr = base_a; iss_val = BYTE_ONES;
                    end
                    F_CHK_BASE: begin
                        iss_ph = F_CHK_LAST; iss_op = OP_READ;
                        iss_addr = last_a; iss_val = BYTE_ONES;
                    end
                    F_CHK_LAST: begin
                        iss_ph = F_WR_BASE; iss_op = OP_WRITE;
                        iss_addr = base_a; iss_val = BYTE_ZEROS;
                    end
                    F_WR_BASE: begin
                        iss_ph = F_RD_BASE; iss_op = OP_READ;
                        iss_addr = base_a; iss_val = BYTE_ZEROS;
                    end
                    F_RD_BASE: begin
                        iss_ph = F_WR_LAST; iss_op = OP_WRITE;
                        iss_addr = last_a; iss_val = BYTE_PATTERN;
                    end
                    F_WR_LAST: begin
                        iss_ph = F_RD_LAST; iss_op = OP_READ;
                        iss_addr = last_a; iss_val = BYTE_PATTERN;
                    end
                    F_RD_LAST: begin
                        iss = 1'b0; beg = 1'b1;
                    end
                    default: begin
                        iss = 1'b0; fin = 1'b1;
                    end
                endcase
            end
        end else begin
            if (byte_read && mismatch) begin
                fin = 1'b1;
            end else begin
                iss = 1'b1;
                case (phase_reg)
                    B_WR_ONES: begin
                        iss_ph = B_RD_ONES; iss_op = OP_READ;
                        iss_addr = position_reg; iss_val = BYTE_ONES;
                    end
                    B_RD_ONES: begin
                        iss_ph = B_WR_ZEROS; iss_op = OP_WRITE;
                        iss_addr = position_reg; iss_val = BYTE_ZEROS;
                    end
                    B_WR_ZEROS: begin
                        iss_ph = B_RD_ZEROS; iss_op = OP_READ;
                        iss_addr = position_reg; iss_val = BYTE_ZEROS;
                    end
                    B_RD_ZEROS: begin
                        iss = 1'b0; beg = 1'b1;
                    end
                    default: begin
                        iss = 1'b0; fin = 1'b1;
                    end
                endcase
            end
        end

        // first operation of the next unit, or pass when all are done
        position_next = position_reg;
        if (beg) begin
            if (unit_done) begin
                fin      = 1'b1;
                fin_pass = 1'b1;
            end else begin
                iss           = 1'b1;
                position_next = new_pos;
                iss_ph        = F_ERASE;
                iss_op        = needs_erase_reg ? OP_ERASE : OP_WRITE;
                iss_addr      = needs_erase_reg ? new_base : new_pos;
                iss_val       = needs_erase_reg ? BYTE_ZEROS : BYTE_ONES;
            end
        end
    end

    // resolve state and result
    always_comb begin
        running_next  = beg ? 1'b1 : running_reg;
        phase_next    = phase_reg;
        expected_next = expected_reg;
        emit          = fin || iss;
        op_next       = OP_DONE;
        addr_next     = '0;
        wval_next     = '0;
        pass_next     = 1'b0;
        if (fin) begin
            running_next = 1'b0;
            phase_next   = F_ERASE;
            pass_next    = fin_pass;
        end else if (iss) begin
            phase_next = iss_ph;
            op_next    = iss_op;
            addr_next  = to_out(iss_addr);
            wval_next  = (iss_op == OP_WRITE) ? iss_val : BYTE_ZEROS;
            if (iss_op == OP_READ) begin
                expected_next = iss_val;
            end
        end
        m_valid_next = proceed ? emit : (m_tready ? 1'b0 : m_valid_reg);
    end

    // test state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            phase_reg    <= F_ERASE;
            position_reg <= '0;
            expected_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (proceed) begin
                running_reg  <= running_next;
                phase_reg    <= phase_next;
                position_reg <= position_next;
                expected_reg <= expected_next;
            end
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (proceed && emit) begin
            op_reg   <= op_next;
            addr_reg <= addr_next;
            wval_reg <= wval_next;
            pass_reg <= pass_next;
        end
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = op_reg;
    assign m_tdata  = {7'b0, pass_reg, wval_reg, addr_reg};

    // checks
    `ASSERT_IMPL(a_done_stops, m_valid_reg && op_reg == OP_DONE, !running_reg,
                 "finished result while test still running")
    `ASSERT_IMPL(a_pass_only_done, m_valid_reg && pass_reg, op_reg == OP_DONE,
                 "pass flag on an operation result")
    `ASSERT_IMPL(a_wval_only_write, m_valid_reg && op_reg != OP_WRITE, wval_reg == BYTE_ZEROS,
                 "write value on a non-write result")
    `ASSERT_CLK(a_phase_legal, running_reg |-> phase_reg != PH_INVALID,
                "running test holds an unused phase")

endmodule

[test/mst_operation_checker.sv]
// operation checker for the memory self-test sequencer: predicts and compares result transactions
module mst_operation_checker
    import mst_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [MEM_SIZE_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,
    input  logic [1:0]            m_tuser,
    output int                    outstanding,
    output int                    mismatches
);

    localparam longint unsigned SECTOR_BYTES = ERASE_BYTES_DEF;
    localparam longint unsigned ADDR_SPAN    = 64'd1 << ADDR_BITS_DEF;

    // one memory operation as it leaves the sequencer
    typedef struct packed {
        op_t                   op;
        logic [ADDR_OUT_W-1:0] addr;
        logic [BYTE_W-1:0]     wval;
        logic                  passed;
    } mem_cmd_t;

    mem_cmd_t expected_cmds[$];

    // configuration copy
    logic                  flash_mode = 1'b0;
    logic [MEM_SIZE_W-1:0] mem_bytes  = '0;

    // sequencer state copy
    logic                  test_active = 1'b0;
    logic [PHASE_W-1:0]    step        = '0;
    logic [ADDR_OUT_W-1:0] unit_pos    = '0;
    logic [BYTE_W-1:0]     want_byte   = '0;

    int fail_count = 0;

    task automatic queue_cmd(input op_t op, input longint unsigned addr,
                             input logic [BYTE_W-1:0] wval, input logic passed);
        mem_cmd_t c;
        c.op     = op;
        c.addr   = addr[ADDR_OUT_W-1:0];
        c.wval   = wval;
        c.passed = passed;
        expected_cmds.push_back(c);
    endtask

    task automatic end_test(input logic passed);
        test_active = 1'b0;
        step        = F_ERASE;
        queue_cmd(OP_DONE, 0, BYTE_ZEROS, passed);
    endtask

    task automatic issue_cmd(input logic [PHASE_W-1:0] next_step, input op_t op,
                             input longint unsigned addr, input logic [BYTE_W-1:0] val);
        step = next_step;
        if (op == OP_READ) begin
            want_byte = val;
        end
        queue_cmd(op, addr, (op == OP_WRITE) ? val : BYTE_ZEROS, 1'b0);
    endtask

    // sectors or bytes to test, size clamped to the address space
    function automatic longint unsigned unit_total();
        longint unsigned bytes;
        bytes = mem_bytes;
        if (bytes > ADDR_SPAN) begin
            bytes = ADDR_SPAN;
        end
        return flash_mode ? bytes / SECTOR_BYTES : bytes;
    endfunction

    // first operation of a sector or byte, or a pass once all are done
    task automatic open_unit(input longint unsigned pos);
        if (pos >= unit_total()) begin
            end_test(1'b1);
        end else begin
            unit_pos = pos[ADDR_OUT_W-1:0];
            if (flash_mode) begin
                issue_cmd(F_ERASE, OP_ERASE, unit_pos * SECTOR_BYTES, BYTE_ZEROS);
            end else begin
                issue_cmd(B_WR_ONES, OP_WRITE, unit_pos, BYTE_ONES);
            end
        end
    endtask

    task automatic predict_next_cmd(input logic cmd, input logic ok, input logic [BYTE_W-1:0] rd);
        longint unsigned base;
        longint unsigned last;
        logic            is_read;
        base = unit_pos * SECTOR_BYTES;
        last = base + SECTOR_BYTES - 1;
        if (cmd == CMD_START) begin
            test_active = 1'b1;
            open_unit(0);
        end else if (!test_active) begin
            // response with no test running: nothing comes out
        end else if (!ok) begin
            end_test(1'b0);
        end else if (flash_mode) begin
            is_read = (step == F_CHK_BASE) || (step == F_CHK_LAST) ||
                      (step == F_RD_BASE) || (step == F_RD_LAST);
            if (is_read && rd != want_byte) begin
                end_test(1'b0);
            end else begin
                case (step)
                    F_ERASE:    issue_cmd(F_CHK_BASE, OP_READ, base, BYTE_ONES);
                    F_CHK_BASE: issue_cmd(F_CHK_LAST, OP_READ, last, BYTE_ONES);
                    F_CHK_LAST: issue_cmd(F_WR_BASE, OP_WRITE, base, BYTE_ZEROS);
                    F_WR_BASE:  issue_cmd(F_RD_BASE, OP_READ, base, BYTE_ZEROS);
                    F_RD_BASE:  issue_cmd(F_WR_LAST, OP_WRITE, last, BYTE_PATTERN);
                    F_WR_LAST:  issue_cmd(F_RD_LAST, OP_READ, last, BYTE_PATTERN);
                    F_RD_LAST:  open_unit(unit_pos + 1);
                    default:    end_test(1'b0);
                endcase
            end
        end else begin
            is_read = (step == B_RD_ONES) || (step == B_RD_ZEROS);
            if (is_read && rd != want_byte) begin
                end_test(1'b0);
            end else begin
                case (step)
                    B_WR_ONES:  issue_cmd(B_RD_ONES, OP_READ, unit_pos, BYTE_ONES);
                    B_RD_ONES:  issue_cmd(B_WR_ZEROS, OP_WRITE, unit_pos, BYTE_ZEROS);
                    B_WR_ZEROS: issue_cmd(B_RD_ZEROS, OP_READ, unit_pos, BYTE_ZEROS);
                    B_RD_ZEROS: open_unit(unit_pos + 1);
                    // flash-only step while in byte mode
                    default:    end_test(1'b0);
                endcase
            end
        end
    endtask

    // watch config writes, results and inputs at each edge
    always @(posedge aclk) begin : watch
        mem_cmd_t got;
        mem_cmd_t want;
        if (!aresetn) begin
            flash_mode  = 1'b0;
            mem_bytes   = '0;
            test_active = 1'b0;
            step        = '0;
            unit_pos    = '0;
            want_byte   = '0;
            expected_cmds.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NEEDS_ERASE) begin
                    flash_mode = cfg_wdata[0];
                end else begin
                    mem_bytes = cfg_wdata;
                end
            end
            // results come from earlier inputs, so compare before predicting
            if (m_tvalid && m_tready) begin
                got.op     = op_t'(m_tuser);
                got.addr   = m_tdata[23:0];
                got.wval   = m_tdata[31:24];
                got.passed = m_tdata[32];
                if (expected_cmds.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result", $time);
                    $display("%0t:   actual op=%0d addr=%h wval=%h passed=%b",
                             $time, got.op, got.addr, got.wval, got.passed);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.op !== want.op || got.addr !== want.addr ||
                        got.wval !== want.wval || got.passed !== want.passed) begin
                        fail_count++;
                        $display("%0t: expected op=%0d addr=%h wval=%h passed=%b", $time,
                                 want.op, want.addr, want.wval, want.passed);
                        $display("%0t:   actual op=%0d addr=%h wval=%h passed=%b", $time,
                                 got.op, got.addr, got.wval, got.passed);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_next_cmd(s_tuser[0], s_tdata[0], s_tdata[8:1]);
            end
        end
        outstanding <= expected_cmds.size();
        mismatches  <= fail_count;
    end

endmodule

[test/memory_self_test_sequencer_tb.sv]
// testbench top for the memory self-test sequencer: memory responder stimulus and verdict
module memory_self_test_sequencer_tb;
    import mst_pkg::*;

    localparam int HOLD_CYCLES = 40;
    localparam int PHASE_ITEMS = 375;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [MEM_SIZE_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // access_ok, read_data, zero pad
    logic [0:0]            s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // target_address, write_value, test_passed, zero pad
    logic [1:0]            m_tuser;   // operation

    int outstanding;
    int mismatches;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_reqs    = 0;
    int holds_served = 0;
    int items_done   = 0;

    // last operation the sequencer handed out, and the memory image it works on
    op_t                   last_op   = OP_DONE;
    logic [ADDR_OUT_W-1:0] last_addr = '0;
    logic [BYTE_W-1:0]     last_wval = '0;
    logic [BYTE_W-1:0]     mem_img [int unsigned];

    memory_self_test_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mst_operation_checker u_ops_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, with an occasional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // track the last operation transaction
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            last_op   <= op_t'(m_tuser);
            last_addr <= m_tdata[23:0];
            last_wval <= m_tdata[31:24];
        end
    end

    // offer one input transaction after a random gap and wait for it to be taken
    task automatic push_item(input logic cmd, input logic ok, input logic [BYTE_W-1:0] rd);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, rd, ok};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending until every predicted result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // registers change only with the pipeline empty
    task automatic write_cfg(input logic erase, input logic [MEM_SIZE_W-1:0] bytes);
        settle();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NEEDS_ERASE;
        cfg_wdata <= MEM_SIZE_W'(erase);
        @(posedge aclk);
        cfg_index <= CFG_MEM_SIZE;
        cfg_wdata <= bytes;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small memories, now and then the extremes
    task automatic write_random_cfg();
        logic                  erase;
        logic [MEM_SIZE_W-1:0] bytes;
        int                    pick;
        erase = 1'($urandom);
        pick  = $urandom_range(99);
        if (pick < 2) begin
            bytes = 25'h1000000;
        end else if (pick < 4) begin
            bytes = 25'h1FFFFFF;
        end else if (pick < 6) begin
            bytes = 25'($urandom);
        end else if (pick < 9) begin
            bytes = '0;
        end else if (erase) begin
            bytes = 25'($urandom_range(0, 4)) * 25'(ERASE_BYTES_DEF) +
                    25'($urandom_range(0, ERASE_BYTES_DEF - 1));
        end else begin
            bytes = 25'($urandom_range(1, 12));
        end
        write_cfg(erase, bytes);
    endtask

    // act as the memory: carry out the last operation and report back
    task automatic answer_last_op(input int fault_permille);
        logic              fault;
        logic [BYTE_W-1:0] rd;
        fault = ($urandom_range(999) < fault_permille);
        rd    = 8'($urandom);
        case (last_op)
            OP_ERASE: begin
                if (!fault) begin
                    for (int i = 0; i < ERASE_BYTES_DEF; i++) begin
                        mem_img[last_addr + i] = BYTE_ONES;
                    end
                end
            end
            OP_WRITE: begin
                if (!fault) begin
                    mem_img[last_addr] = last_wval;
                end
            end
            OP_READ: begin
                if (mem_img.exists(last_addr)) begin
                    rd = mem_img[last_addr];
                end
                // half the read faults come back as a corrupted byte
                if (fault && $urandom_range(1)) begin
                    rd    = rd ^ 8'($urandom_range(1, 255));
                    fault = 1'b0;
                end
            end
            default: ;
        endcase
        push_item(CMD_RESPONSE, !fault, rd);
    endtask

    // one test from start to finished, with rare restarts and live config changes
    task automatic run_test(input int max_steps, input int fault_permille);
        int r;
        push_item(CMD_START, 1'($urandom), 8'($urandom));
        settle();
        items_done++;
        for (int n = 0; n < max_steps && last_op != OP_DONE; n++) begin
            r = $urandom_range(199);
            if (r == 0) begin
                push_item(CMD_START, 1'($urandom), 8'($urandom));
            end else begin
                if (r == 1) begin
                    write_random_cfg();
                end
                answer_last_op(fault_permille);
            end
            settle();
            items_done++;
        end
    endtask

    // stimulus
    initial begin
        int phase_end;
        int r;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_NEEDS_ERASE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_START;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // response with no test running is dropped
        push_item(CMD_RESPONSE, 1'b1, BYTE_ONES);
        settle();
        // single byte, full byte-mode pass
        write_cfg(1'b0, 25'd1);
        run_test(8, 0);
        // one sector, the partial sector after it is skipped
        write_cfg(1'b1, 25'd8191);
        run_test(10, 0);
        // less than a sector: passes at once
        write_cfg(1'b1, 25'd4095);
        run_test(2, 0);
        // failed access
        write_cfg(1'b0, 25'd2);
        push_item(CMD_START, 1'b0, BYTE_ZEROS);
        push_item(CMD_RESPONSE, 1'b0, BYTE_ONES);
        // read data on a write response ignored, restart while running, wrong byte
        push_item(CMD_START, 1'b1, BYTE_ONES);
        push_item(CMD_RESPONSE, 1'b1, 8'hA5);
        push_item(CMD_START, 1'b0, BYTE_ZEROS);
        push_item(CMD_RESPONSE, 1'b1, BYTE_ZEROS);
        push_item(CMD_RESPONSE, 1'b1, 8'h7E);
        settle();
        // switch to byte mode while a flash read-back step is outstanding
        write_cfg(1'b1, 25'd8192);
        push_item(CMD_START, 1'b1, BYTE_ZEROS);
        settle();
        repeat (4) begin
            answer_last_op(0);
            settle();
        end
        write_cfg(1'b0, 25'd8192);
        answer_last_op(0);
        settle();
        // oversized memory clamps to the address space
        write_cfg(1'b1, 25'h1FFFFFF);
        push_item(CMD_START, 1'b0, BYTE_PATTERN);
        push_item(CMD_RESPONSE, 1'b0, BYTE_ZEROS);
        settle();

        // random tests under each idling mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            // long result hold-off while inputs keep coming
            hold_reqs++;
            repeat (12) push_item(1'($urandom), 1'($urandom), 8'($urandom));
            settle();
            phase_end = items_done + PHASE_ITEMS;
            while (items_done < phase_end) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    repeat ($urandom_range(1, 6)) begin
                        push_item(1'($urandom), 1'($urandom), 8'($urandom));
                    end
                    settle();
                end else begin
                    if (r < 55) begin
                        write_random_cfg();
                    end
                    run_test(100, 8);
                end
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
